FILE: sv/pss_pkg.sv
// Package: shared constants, types and helper functions for path sphere selection.
package pss_pkg;

    localparam int MaxSpheres = 64;
    localparam int FracBits   = 12;
    localparam int IdxW       = $clog2(MaxSpheres);
    localparam int CntW       = $clog2(MaxSpheres + 1);
    localparam int PosW       = 24;
    localparam int RadW       = 23;
    localparam int DiffW      = PosW + 1;
    localparam int SqW        = 2 * DiffW;
    localparam int SumW       = SqW + 2;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [RadW-1:0] RadiusReset = RadW'(2048);

    localparam logic signed [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
    localparam logic signed [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};

    // Command from the controller to the datapath
    typedef struct packed {
        logic load;     // capture the item
        logic store;    // write a sphere
        logic clear;    // empty the table
        logic start;    // reset scan
        logic step;     // compare one sphere
        logic finish;   // fold scan result, build result
    } pss_cmd_t;

    // Status from the datapath
    typedef struct packed {
        logic full;
        logic scan_last;  // last compare issued this cycle
        logic scan_empty; // no sphere to scan, or NaN bounce
    } pss_stat_t;

    // Convert a half word to signed fixed point with saturation
    function automatic logic signed [PosW-1:0] half_to_fixed(input logic [15:0] h);
        logic        neg;
        logic [4:0]  e;
        logic [10:0] sig;
        int          sh;
        int          r;
        logic [40:0] mag;
        logic [40:0] tmp;
        neg = h[15];
        e   = h[14:10];
        sig = (e == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
        sh  = ((e == 5'd0) ? 1 : int'(e)) - 25 + FracBits;
        r   = -sh;
        mag = '0;
        tmp = '0;
        if (e == 5'h1F)
        begin
            half_to_fixed = neg ? PosMin : PosMax;
        end
        else
        begin
            if (sig == 11'd0)
            begin
                mag = '0;
            end
            else if (sh >= 0)
            begin
                if (sh >= PosW)
                    mag = 41'd1 << PosW;
                else
                    mag = 41'(sig) << sh;
            end
            else
            begin
                if (r >= 40)
                    mag = '0;
                else
                begin
                    tmp = 41'(sig) + (41'd1 << (r - 1));
                    mag = tmp >> r;
                end
            end
            if (neg)
                half_to_fixed = (mag >= 41'h800000) ? PosMin : -PosW'(mag);
            else
                half_to_fixed = (mag > 41'h7FFFFF) ? PosMax : PosW'(mag);
        end
    endfunction

endpackage

FILE: sv/path_sphere_selection.sv
// Top level: path sphere selection with stream ports and a radius register port.
// Each item gives exactly one result. Add, clear and the unused code set their result
// when the item is accepted; a test bounce scans all N stored spheres (none when the
// table is empty or the bounce is NaN) through the single squared-distance unit that
// compares one table entry per cycle. The next item is taken once the previous result
// has left the output register.
module path_sphere_selection
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: pos_x[23:0], pos_y[47:24], pos_z[71:48], bounce_x[87:72],
    // bounce_y[103:88], bounce_z[119:104], path_index[143:120], pad[151:144]
    input  logic [151:0] s_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[0], path_done[1], done_path_index[25:2], path_selected[26], pad[31:27]
    output logic [31:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [22:0]  cfg_data
);

    pss_pkg::pss_cmd_t  cmd;
    pss_pkg::pss_stat_t stat;
    logic               busy;
    logic               res_set;
    logic               out_valid_reg;
    logic [22:0]        radius_reg;
    logic [26:0]        result;
    logic               in_fire;

    assign s_tready  = !busy;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Hold the brush radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= pss_pkg::RadiusReset;
        else if (cfg_valid)
            radius_reg <= cfg_data;
    end

    // Output valid: set by controller, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_set)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    pss_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .op            (s_tuser),
        .out_free      (!out_valid_reg),
        .stat          (stat),
        .busy          (busy),
        .res_valid_set (res_set),
        .cmd           (cmd)
    );

    pss_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .pos_x        (s_tdata[23:0]),
        .pos_y        (s_tdata[47:24]),
        .pos_z        (s_tdata[71:48]),
        .bounce_x     (s_tdata[87:72]),
        .bounce_y     (s_tdata[103:88]),
        .bounce_z     (s_tdata[119:104]),
        .path_index   (s_tdata[143:120]),
        .last_of_path (s_tlast),
        .brush_radius (radius_reg),
        .stat         (stat),
        .result       (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, result};

endmodule

FILE: sv/pss_ctrl.sv
// Controller: sequences add, clear and test items and the sphere scan.
module pss_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [1:0]          op,
    input  logic                out_free,
    input  pss_pkg::pss_stat_t  stat,
    output logic                busy,
    output logic                res_valid_set,
    output pss_pkg::pss_cmd_t   cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Issue commands; S_WAIT lets the last registered sphere read reach the compare
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        res_valid_set = 1'b0;
        busy          = (state_reg != S_IDLE) || !out_free;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    if (op == pss_pkg::OP_TEST)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        cmd.store     = (op == pss_pkg::OP_ADD);
                        cmd.clear     = (op == pss_pkg::OP_CLEAR);
                        res_valid_set = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (stat.scan_empty)
                    state_next = S_DONE;
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.scan_last)
                        state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish    = 1'b1;
                res_valid_set = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A result is only raised when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_set |-> out_free)
        else $error("result raised while output occupied");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |=> (state_reg == S_DONE))
        else $error("drain did not finish");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (state_reg == S_IDLE))
        else $error("item accepted while busy");

endmodule

FILE: sv/pss_dp.sv
// Datapath: sphere table, half conversion and squared-distance compare.
module pss_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pss_pkg::pss_cmd_t                   cmd,
    input  logic signed [pss_pkg::PosW-1:0]     pos_x,
    input  logic signed [pss_pkg::PosW-1:0]     pos_y,
    input  logic signed [pss_pkg::PosW-1:0]     pos_z,
    input  logic [15:0]                         bounce_x,
    input  logic [15:0]                         bounce_y,
    input  logic [15:0]                         bounce_z,
    input  logic [23:0]                         path_index,
    input  logic                                last_of_path,
    input  logic [pss_pkg::RadW-1:0]            brush_radius,
    output pss_pkg::pss_stat_t                  stat,
    output logic [26:0]                         result
);

    localparam int PosW = pss_pkg::PosW;
    localparam int IdxW = pss_pkg::IdxW;
    localparam int CntW = pss_pkg::CntW;

    logic signed [PosW-1:0] cx_mem [pss_pkg::MaxSpheres];
    logic signed [PosW-1:0] cy_mem [pss_pkg::MaxSpheres];
    logic signed [PosW-1:0] cz_mem [pss_pkg::MaxSpheres];
    logic [pss_pkg::RadW-1:0] r_mem [pss_pkg::MaxSpheres];

    logic [CntW-1:0] count_reg;
    logic            hit_reg;
    logic [CntW-1:0] scan_reg;
    logic            nan_reg;
    logic            scan_hit_reg;
    logic            rd_valid_reg;
    logic signed [PosW-1:0] bx_reg, by_reg, bz_reg;
    logic signed [PosW-1:0] cx_rd_reg, cy_rd_reg, cz_rd_reg;
    logic [pss_pkg::RadW-1:0] r_rd_reg;
    logic [23:0] idx_reg;
    logic        last_reg;
    logic [26:0] result_reg;

    logic signed [pss_pkg::DiffW-1:0] dx, dy, dz;
    logic signed [pss_pkg::SqW-1:0] sx, sy, sz;
    logic [pss_pkg::SumW-1:0] d2;
    logic [2*pss_pkg::RadW-1:0] r2;
    logic is_nan;
    logic hit_any;

    assign is_nan = ((bounce_x[14:10] == 5'h1F) && (bounce_x[9:0] != 10'd0))
                 || ((bounce_y[14:10] == 5'h1F) && (bounce_y[9:0] != 10'd0))
                 || ((bounce_z[14:10] == 5'h1F) && (bounce_z[9:0] != 10'd0));

    assign stat.full       = (count_reg == CntW'(pss_pkg::MaxSpheres));
    assign stat.scan_empty = (count_reg == '0) || nan_reg;
    assign stat.scan_last  = (scan_reg == count_reg - CntW'(1));

    // Write table and register the sphere read for the compare
    always_ff @(posedge clk)
    begin
        if (cmd.store && !stat.full)
        begin
            cx_mem[count_reg[IdxW-1:0]] <= pos_x;
            cy_mem[count_reg[IdxW-1:0]] <= pos_y;
            cz_mem[count_reg[IdxW-1:0]] <= pos_z;
            r_mem[count_reg[IdxW-1:0]]  <= brush_radius;
        end
        if (cmd.step)
        begin
            cx_rd_reg <= cx_mem[scan_reg[IdxW-1:0]];
            cy_rd_reg <= cy_mem[scan_reg[IdxW-1:0]];
            cz_rd_reg <= cz_mem[scan_reg[IdxW-1:0]];
            r_rd_reg  <= r_mem[scan_reg[IdxW-1:0]];
        end
    end

    // Compare one sphere read in the previous cycle
    always_comb
    begin
        dx = pss_pkg::DiffW'(bx_reg) - pss_pkg::DiffW'(cx_rd_reg);
        dy = pss_pkg::DiffW'(by_reg) - pss_pkg::DiffW'(cy_rd_reg);
        dz = pss_pkg::DiffW'(bz_reg) - pss_pkg::DiffW'(cz_rd_reg);
        sx = dx * dx;
        sy = dy * dy;
        sz = dz * dz;
        d2 = pss_pkg::SumW'(sx) + pss_pkg::SumW'(sy) + pss_pkg::SumW'(sz);
        r2 = r_rd_reg * r_rd_reg;
        hit_any = scan_hit_reg || (rd_valid_reg && (d2 <= pss_pkg::SumW'(r2)));
    end

    // Payload capture and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg  <= path_index;
            last_reg <= last_of_path;
            bx_reg   <= pss_pkg::half_to_fixed(bounce_x);
            by_reg   <= pss_pkg::half_to_fixed(bounce_y);
            bz_reg   <= pss_pkg::half_to_fixed(bounce_z);
            nan_reg  <= is_nan;
        end
        if (cmd.store)
            result_reg <= {26'd0, stat.full};
        else if (cmd.load)
            result_reg <= '0;
        else if (cmd.finish)
            result_reg <= last_reg ? {hit_reg || hit_any, idx_reg, 1'b1, 1'b0} : 27'd0;
    end

    // Control state of the table and scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            hit_reg      <= 1'b0;
            scan_reg     <= '0;
            scan_hit_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.step;
            if (cmd.store && !stat.full)
                count_reg <= count_reg + CntW'(1);
            if (cmd.clear)
            begin
                count_reg <= '0;
                hit_reg   <= 1'b0;
            end
            if (cmd.start)
            begin
                scan_reg     <= '0;
                scan_hit_reg <= 1'b0;
            end
            else
            begin
                if (cmd.step)
                    scan_reg <= scan_reg + CntW'(1);
                scan_hit_reg <= hit_any;
            end
            if (cmd.finish)
                hit_reg <= last_reg ? 1'b0 : (hit_reg || hit_any);
        end
    end

    assign result = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(pss_pkg::MaxSpheres))
        else $error("sphere count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (scan_reg < count_reg))
        else $error("scan past table end");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !rd_valid_reg)
        else $error("compare pending after finish");

endmodule

FILE: tb/path_sphere_selection_test.sv
// Testbench for path sphere selection: directed and random items checked against a predictor.
module path_sphere_selection_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 20000;

    typedef struct packed {
        logic        path_selected;
        logic [23:0] done_path_index;
        logic        path_done;
        logic        status;
    } verdict_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [22:0]  cfg_data;

    // Predictor state
    logic [22:0]        radius_now;
    logic signed [23:0] ctr_x [pss_pkg::MaxSpheres];
    logic signed [23:0] ctr_y [pss_pkg::MaxSpheres];
    logic signed [23:0] ctr_z [pss_pkg::MaxSpheres];
    logic [22:0]        ctr_r [pss_pkg::MaxSpheres];
    int                 table_fill;
    logic               hit_flag;

    verdict_t verdict_queue[$];
    int       error_count;
    int       result_count;
    int       item_count;
    int       idle_cycles;
    logic     out_stall_on;

    path_sphere_selection i_dut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Half word to signed Q12.12 with rounding ties away and saturation
    function automatic logic signed [23:0] fixed_from_half(input logic [15:0] h,
                                                           output logic is_nan);
        logic [4:0]  ex;
        logic [10:0] sg;
        int          shift;
        longint      mag;
        ex = h[14:10];
        sg = (ex == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
        shift = ((ex == 5'd0) ? 1 : int'(ex)) - 25 + pss_pkg::FracBits;
        is_nan = 1'b0;
        if (ex == 5'h1F)
        begin
            is_nan = (h[9:0] != 10'd0);
            if (is_nan)
                return 24'sd0;
            return h[15] ? -24'sd8388608 : 24'sd8388607;
        end
        if (sg == 0)
            mag = 0;
        else if (shift >= 0)
            mag = (shift >= 24) ? (64'd1 << 24) : (longint'(sg) << shift);
        else if (-shift >= 40)
            mag = 0;
        else
            mag = (longint'(sg) + (64'd1 << (-shift - 1))) >>> (-shift);
        if (h[15])
            return (mag >= 8388608) ? -24'sd8388608 : 24'(-mag);
        return (mag > 8388607) ? 24'sd8388607 : 24'(mag);
    endfunction

    // Work out the result of one item and advance the predictor
    function automatic verdict_t predict_verdict(input logic [1:0] op,
                                                 input logic [151:0] d, input logic last);
        verdict_t v;
        logic     n0, n1, n2;
        logic signed [23:0] bx, by, bz;
        longint   dx, dy, dz, r;
        v = '0;
        if (op == pss_pkg::OP_ADD)
        begin
            if (table_fill < pss_pkg::MaxSpheres)
            begin
                ctr_x[table_fill] = d[23:0];
                ctr_y[table_fill] = d[47:24];
                ctr_z[table_fill] = d[71:48];
                ctr_r[table_fill] = radius_now;
                table_fill++;
            end
            else
                v.status = 1'b1;
        end
        else if (op == pss_pkg::OP_CLEAR)
        begin
            table_fill = 0;
            hit_flag = 1'b0;
        end
        else if (op == pss_pkg::OP_TEST)
        begin
            bx = fixed_from_half(d[87:72], n0);
            by = fixed_from_half(d[103:88], n1);
            bz = fixed_from_half(d[119:104], n2);
            if (!(n0 | n1 | n2))
                for (int i = 0; i < table_fill; i++)
                begin
                    dx = longint'(bx) - longint'(ctr_x[i]);
                    dy = longint'(by) - longint'(ctr_y[i]);
                    dz = longint'(bz) - longint'(ctr_z[i]);
                    r = longint'(ctr_r[i]);
                    if (dx * dx + dy * dy + dz * dz <= r * r)
                        hit_flag = 1'b1;
                end
            if (last)
            begin
                v.path_done = 1'b1;
                v.done_path_index = d[143:120];
                v.path_selected = hit_flag;
                hit_flag = 1'b0;
            end
        end
        return v;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 5)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    // Send one item: hold valid until the transfer, drop it only before a gap
    task automatic send_item(input logic [1:0] op, input logic [151:0] d, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {8'd0, d[143:0]};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        verdict_queue = {verdict_queue, predict_verdict(op, {8'd0, d[143:0]}, last)};
        item_count++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (verdict_queue.size() != 0)
            @(negedge clk);
        repeat (pss_pkg::MaxSpheres + 8) @(negedge clk);
    endtask

    // Write the radius register; only called with nothing in flight
    task automatic write_radius(input logic [22:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        radius_now = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [151:0] pack_add(input logic [23:0] x, input logic [23:0] y,
                                              input logic [23:0] z);
        return {8'd0, 24'd0, 48'd0, z, y, x};
    endfunction

    function automatic logic [151:0] pack_test(input logic [15:0] hx, input logic [15:0] hy,
                                               input logic [15:0] hz, input logic [23:0] p);
        return {8'd0, p, hz, hy, hx, 72'd0};
    endfunction

    // Random half word: mostly near sphere scale, sometimes any pattern
    function automatic logic [15:0] rand_half();
        if ($urandom_range(0, 9) < 2)
            return 16'($urandom);
        return {1'($urandom), 5'($urandom_range(8, 17)), 10'($urandom)};
    endfunction

    // Directed: extremes, every operation and the named special cases
    task automatic test_directed();
        send_item(pss_pkg::OP_TEST, pack_test(16'h0000, 16'h0000, 16'h0000, 24'hFFFFFF), 1'b1);
        send_item(pss_pkg::OP_ADD, pack_add(24'h000000, 24'h000000, 24'h000000), 1'b0);
        send_item(pss_pkg::OP_TEST, pack_test(16'h8000, 16'h3C00, 16'h0000, 24'd1), 1'b0);
        send_item(pss_pkg::OP_TEST, pack_test(16'h7E00, 16'h0000, 16'h0000, 24'd1), 1'b1);
        send_item(pss_pkg::OP_TEST, pack_test(16'h3C00, 16'h0000, 16'h0000, 24'd2), 1'b1);
        send_item(pss_pkg::OP_TEST, pack_test(16'h0001, 16'h83FF, 16'h0400, 24'd3), 1'b1);
        send_item(pss_pkg::OP_ADD, pack_add(24'h7FFFFF, 24'h800000, 24'h7FFFFF), 1'b1);
        send_item(pss_pkg::OP_TEST, pack_test(16'h7C00, 16'hFC00, 16'h7C00, 24'd4), 1'b1);
        send_item(pss_pkg::OP_TEST, pack_test(16'h7BFF, 16'hFBFF, 16'h7BFF, 24'd5), 1'b1);
        send_item(pss_pkg::OP_TEST, pack_test(16'hFFFF, 16'h7C01, 16'h0000, 24'd6), 1'b1);
        send_item(pss_pkg::OP_UNUSED, 152'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF, 1'b1);
        send_item(pss_pkg::OP_CLEAR, 152'd0, 1'b0);
        send_item(pss_pkg::OP_TEST, pack_test(16'h0000, 16'h0000, 16'h0000, 24'd7), 1'b1);
        write_radius(23'h7FFFFF);
        send_item(pss_pkg::OP_ADD, pack_add(24'h800000, 24'h800000, 24'h800000), 1'b0);
        send_item(pss_pkg::OP_TEST, pack_test(16'h7C00, 16'h7C00, 16'h7C00, 24'd8), 1'b1);
        write_radius(23'd0);
        send_item(pss_pkg::OP_CLEAR, 152'd0, 1'b0);
        // Zero radius: only an exact center hit, boundary counts as inside
        send_item(pss_pkg::OP_ADD, pack_add(24'h001000, 24'h000000, 24'h000000), 1'b0);
        send_item(pss_pkg::OP_TEST, pack_test(16'h3C00, 16'h0000, 16'h8000, 24'd9), 1'b1);
        send_item(pss_pkg::OP_TEST, pack_test(16'h3C01, 16'h0000, 16'h0000, 24'd10), 1'b1);
        write_radius(23'd4096);
        send_item(pss_pkg::OP_TEST, pack_test(16'h4000, 16'h0000, 16'h0000, 24'd11), 1'b1);
    endtask

    // Fill the table past its end to hit the full case
    task automatic test_table_full();
        write_radius(pss_pkg::RadiusReset);
        send_item(pss_pkg::OP_CLEAR, 152'd0, 1'b0);
        for (int i = 0; i < pss_pkg::MaxSpheres + 3; i++)
            send_item(pss_pkg::OP_ADD, pack_add(24'($urandom), 24'($urandom), 24'($urandom)),
                      1'b0);
        send_item(pss_pkg::OP_TEST, pack_test(rand_half(), rand_half(), rand_half(),
                                              24'($urandom)), 1'b1);
    endtask

    // Random phases: small tables, paths of a few bounces, some noise
    task automatic test_random_paths();
        int n;
        for (int phase = 0; phase < 10; phase++)
        begin
            write_radius((phase % 3 == 0) ? 23'($urandom) : 23'($urandom_range(1024, 40000)));
            send_item(pss_pkg::OP_CLEAR, 152'd0, 1'b0);
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++)
                send_item(pss_pkg::OP_ADD, pack_add(24'($signed(13'($urandom)) <<< 6),
                                                    24'($signed(13'($urandom)) <<< 6),
                                                    24'($signed(13'($urandom)) <<< 6)), 1'b0);
            for (int p = 0; p < 32; p++)
            begin
                n = $urandom_range(1, 4);
                for (int b = 0; b < n; b++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(2'($urandom), 152'({$urandom, $urandom, $urandom,
                                  $urandom, $urandom}), 1'($urandom));
                    send_item(pss_pkg::OP_TEST, pack_test(rand_half(), rand_half(), rand_half(),
                                                          24'($urandom)), b == n - 1);
                end
                // Hold off until everything expected has come back
                if (p == 16)
                begin
                    s_tvalid <= 1'b0;
                    while (verdict_queue.size() != 0)
                        @(negedge clk);
                end
            end
        end
    endtask

    // Check each output transfer against the oldest prediction
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (verdict_queue.size() == 0)
                report_mismatch("unexpected result", m_tdata, 32'd0);
            else
            begin
                want = verdict_queue.pop_front();
                if (m_tdata[0] !== want.status)
                    report_mismatch("status", m_tdata[0], want.status);
                if (m_tdata[1] !== want.path_done)
                    report_mismatch("path_done", m_tdata[1], want.path_done);
                if (m_tdata[25:2] !== want.done_path_index)
                    report_mismatch("done_path_index", m_tdata[25:2], want.done_path_index);
                if (m_tdata[26] !== want.path_selected)
                    report_mismatch("path_selected", m_tdata[26], want.path_selected);
            end
        end
    end

    // Random receiver stalls
    always @(negedge clk)
    begin
        if (out_stall_on)
        begin
            m_tready <= 1'b0;
            if (idle_cycles > 0)
                idle_cycles--;
            else
                out_stall_on <= 1'b0;
        end
        else if (($urandom_range(0, 299) < 2) || ($urandom_range(0, 9) < 2))
        begin
            idle_cycles = pick_gap();
            out_stall_on <= 1'b1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog on cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= StallLimit)
            begin
                $display("watchdog: no transfer for %0d cycles", quiet);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        out_stall_on = 1'b0;
        idle_cycles = 0;
        error_count = 0;
        result_count = 0;
        item_count = 0;
        radius_now = pss_pkg::RadiusReset;
        table_fill = 0;
        hit_flag = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_table_full();
        test_random_paths();
        wait_drained();
        $display("covered %0d items and %0d results over directed, full-table and random phases",
                 item_count, result_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
